[design/amdh_pkg.sv]
`default_nettype none
package amdh_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       start_message;
        logic       restart_from_iv;
        logic       end_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest;
        logic        partial_dropped;
    } t_out_item;

    // queued job for the back part
    typedef struct packed {
        logic [127:0] block;
        logic         do_compress;
        logic         load_iv;
        logic [31:0]  iv;
        logic         finish;
        logic         dropped;
    } t_job;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [31:0] IV_RESET = 32'h78563412;
    localparam logic CFG_IV = 1'b0;
    localparam logic CFG_PAD = 1'b1;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

endpackage
`default_nettype wire

[design/amdh_front.sv]
`default_nettype none
module amdh_front
    import amdh_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cfg_we,
    input  wire logic     i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic     i_valid,
    output logic          o_stall,
    input  wire t_in_item i_item,
    output logic          o_job_valid,
    input  wire logic     i_job_stall,
    output t_job          o_job
);
    logic [31:0]  r_iv;
    logic         r_pad;
    logic [127:0] r_buf;
    logic [3:0]   r_fill;
    logic [63:0]  r_len;
    logic         r_tail;       // second padding job owed
    logic         r_tail_pad;   // tail block starts with the pad byte
    logic [63:0]  r_tail_len;
    logic [3:0]   n_fill;
    logic [63:0]  n_len;
    logic [127:0] n_buf, pad_blk;
    logic         full, accept, busy_free;
    t_job         job;

    assign o_stall = r_tail || i_job_stall;
    assign accept  = i_valid && !o_stall;
    assign busy_free = !i_job_stall;

    always_comb begin
        n_fill = i_item.start_message ? 4'd0 : r_fill;
        n_len  = i_item.start_message ? 64'd0 : r_len;
        n_buf  = r_buf;
        full   = 1'b0;
        if (i_item.byte_present) begin
            n_buf[n_fill*8 +: 8] = i_item.data_byte;
            full   = (n_fill == 4'd15);
            n_fill = n_fill + 4'd1;
            n_len  = n_len + 64'd1;
        end
        pad_blk = '0;
        for (int k = 0; k < 16; k++) begin
            if (k < n_fill) pad_blk[k*8 +: 8] = n_buf[k*8 +: 8];
        end
        pad_blk[n_fill*8 +: 8] = PAD_BYTE;
        if (n_fill < 4'd8) pad_blk[127:64] = n_len;

        job = '0;
        job.load_iv = i_item.start_message && i_item.restart_from_iv;
        job.iv = r_iv;
        if (r_tail) begin
            job.block = {r_tail_len, 56'd0, (r_tail_pad ? PAD_BYTE : 8'h00)};
            job.do_compress = 1'b1;
            job.finish = 1'b1;
            job.load_iv = 1'b0;
        end else begin
            job.block = full ? n_buf : pad_blk;
            job.do_compress = full;
            if (i_item.end_message && !full) begin
                if (r_pad) begin
                    job.do_compress = 1'b1;
                    job.finish = (n_fill < 4'd8);
                end else begin
                    job.finish = 1'b1;
                    job.dropped = (n_fill != 4'd0);
                end
            end else if (i_item.end_message && full) begin
                // whole block, then in padding mode a padding block with pad byte and length
                job.finish = !r_pad;
            end
        end
    end

    assign o_job = job;
    assign o_job_valid = r_tail || (i_valid && !r_tail);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= IV_RESET;
            r_pad <= 1'b1;
            r_fill <= '0;
            r_len <= '0;
            r_tail <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_IV) r_iv <= i_cfg_data;
                else r_pad <= i_cfg_data[0];
            end
            if (r_tail && busy_free) begin
                r_tail <= 1'b0;
            end else if (accept) begin
                r_buf <= n_buf;
                r_fill <= i_item.end_message ? 4'd0 : n_fill;
                r_len <= i_item.end_message ? 64'd0 : n_len;
                r_tail_len <= n_len;
                r_tail_pad <= full;
                r_tail <= i_item.end_message && r_pad &&
                          (full || n_fill >= 4'd8);
            end
        end
    end
endmodule
`default_nettype wire

[design/amdh_queue.sv]
`default_nettype none
module amdh_queue
    import amdh_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_job      o_job
);
    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign push = i_valid && !o_stall;
    assign pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= !r_wp;
            if (pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

[design/amdh_back.sv]
`default_nettype none
module amdh_back
    import amdh_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_job i_job,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out_item o_item
);
    logic [31:0]  r_chain;
    logic [127:0] r_state, r_key;
    logic [3:0]   r_round;
    logic         r_busy, r_fin, r_ovalid;
    logic [7:0]   r_rcon;
    t_out_item    r_out;
    logic [31:0]  chain_in;
    logic [127:0] sr, mc, nkey, nstate;
    logic [31:0]  rot;
    logic         take, out_free, out_set;

    assign out_free = !r_ovalid || !i_stall;
    assign o_stall  = r_busy || !out_free;
    assign take     = i_valid && !o_stall;
    assign chain_in = i_job.load_iv ? i_job.iv : r_chain;
    assign o_valid  = r_ovalid;
    assign o_item   = r_out;
    assign out_set  = (r_busy && (r_round == 4'd10) && r_fin) ||
                      (take && !i_job.do_compress && i_job.finish);

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                sr[(c*4+i)*8 +: 8] = SBOX[r_state[(((c+i)%4)*4+i)*8 +: 8]];
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a0, a1, a2, a3, al;
            a0 = sr[(c*4)*8 +: 8];   a1 = sr[(c*4+1)*8 +: 8];
            a2 = sr[(c*4+2)*8 +: 8]; a3 = sr[(c*4+3)*8 +: 8];
            al = a0 ^ a1 ^ a2 ^ a3;
            mc[(c*4)*8 +: 8]   = a0 ^ al ^ xtime(a0 ^ a1);
            mc[(c*4+1)*8 +: 8] = a1 ^ al ^ xtime(a1 ^ a2);
            mc[(c*4+2)*8 +: 8] = a2 ^ al ^ xtime(a2 ^ a3);
            mc[(c*4+3)*8 +: 8] = a3 ^ al ^ xtime(a3 ^ a0);
        end
        rot = {SBOX[r_key[103:96]], SBOX[r_key[127:120]],
               SBOX[r_key[119:112]], SBOX[r_key[111:104]] ^ r_rcon};
        nkey[31:0]   = r_key[31:0] ^ rot;
        nkey[63:32]  = r_key[63:32] ^ nkey[31:0];
        nkey[95:64]  = r_key[95:64] ^ nkey[63:32];
        nkey[127:96] = r_key[127:96] ^ nkey[95:64];
        nstate = ((r_round == 4'd10) ? sr : mc) ^ nkey;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= IV_RESET;
            r_busy <= 1'b0;
            r_ovalid <= 1'b0;
            r_fin <= 1'b0;
        end else begin
            if (out_set) r_ovalid <= 1'b1;
            else if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            if (r_busy) begin
                r_state <= nstate;
                r_key <= nkey;
                r_rcon <= xtime(r_rcon);
                r_round <= r_round + 4'd1;
                if (r_round == 4'd10) begin
                    r_busy <= 1'b0;
                    r_chain <= nstate[31:0];
                    if (r_fin) begin
                        r_out.digest <= nstate[31:0];
                        r_out.partial_dropped <= 1'b0;
                    end
                end
            end else if (take) begin
                r_chain <= chain_in;
                if (i_job.do_compress) begin
                    r_busy <= 1'b1;
                    r_fin <= i_job.finish;
                    r_state <= i_job.block ^ {96'd0, chain_in};
                    r_key <= {96'd0, chain_in};
                    r_rcon <= 8'h01;
                    r_round <= 4'd1;
                end else if (i_job.finish) begin
                    r_out.digest <= chain_in;
                    r_out.partial_dropped <= i_job.dropped;
                end
            end
        end
    end
endmodule
`default_nettype wire

[design/aes_merkle_damgard_hash.sv]
// the digest follows the last item through the front, the queue and the round unit, after
// a second block when padding spills over; in no-padding mode with no block to compress
// the chain value goes out as is; one item a cycle goes into a two-entry queue unless it
// is full or a padding job is owed; a full block holds the round unit for all its rounds
// synchronous active-low reset restores initial value and padding enable, empties the queue
`default_nettype none
module aes_merkle_damgard_hash
    import amdh_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_cfg_we,
    input  wire logic      i_cfg_idx,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic      i_valid,
    output logic           o_stall,
    input  wire t_in_item  i_item,
    output logic           o_valid,
    input  wire logic      i_stall,
    output t_out_item      o_item
);
    logic f_v, f_s, b_v, b_s;
    t_job f_j, b_j;

    amdh_front u_front (.i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_stall, .i_item, .o_job_valid(f_v), .i_job_stall(f_s), .o_job(f_j));
    amdh_queue u_queue (.i_clk, .i_rst_n, .i_valid(f_v), .o_stall(f_s), .i_job(f_j),
        .o_valid(b_v), .i_stall(b_s), .o_job(b_j));
    amdh_back u_back (.i_clk, .i_rst_n, .i_valid(b_v), .o_stall(b_s), .i_job(b_j),
        .o_valid, .i_stall, .o_item);
endmodule
`default_nettype wire

[design/amdh_checker.sv]
`default_nettype none
module amdh_checker
    import amdh_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic o_valid,
    input wire logic i_stall,
    input wire t_out_item o_item
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item)) else $error("out item changed");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("valid after reset");
    a_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$isunknown(o_valid)) else $error("valid unknown");
endmodule

bind aes_merkle_damgard_hash amdh_checker u_chk (.i_clk, .i_rst_n, .o_valid, .i_stall, .o_item);
`default_nettype wire

[dv/tb_aes_merkle_damgard_hash.sv]
`default_nettype none
module tb_aes_merkle_damgard_hash;
    import amdh_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;
    logic        i_valid;
    logic        o_stall;
    t_in_item    i_item;
    logic        o_valid;
    logic        i_stall;
    t_out_item   o_item;

    aes_merkle_damgard_hash dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_stall(o_stall), .i_item(i_item),
        .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    // s-box kept locally for the digest prediction
    logic [7:0] sub_tab [256];
    initial begin
        sub_tab = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
        };
    end

    // predictor state
    logic [31:0] model_iv;
    logic        model_pad;
    logic [31:0] model_chain;
    logic [7:0]  model_buf [16];
    logic [4:0]  model_fill;
    logic [63:0] model_len;

    t_in_item    pending_items [$];
    t_out_item   expected_digests [$];
    int          errors;
    int          sender_idle_pct;
    int          receiver_stall_pct;
    int          hold_cycles;
    longint      cycle_count;

    function automatic logic [7:0] gmul2(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // first 4 ciphertext bytes of aes-128 with key = chain bytes then zeros
    function automatic logic [31:0] compress(input logic [31:0] chain, input logic [7:0] blk [16]);
        logic [7:0] rk [176];
        logic [7:0] st [16];
        logic [7:0] tt [16];
        logic [7:0] w [4];
        logic [7:0] rc;
        logic [7:0] w0;
        logic [7:0] a0, a1, a2, a3, al;
        rc = 8'h01;
        for (int i = 0; i < 16; i++) rk[i] = (i < 4) ? chain[8*i +: 8] : 8'h00;
        for (int i = 16; i < 176; i += 4) begin
            for (int c = 0; c < 4; c++) w[c] = rk[i-4+c];
            if ((i % 16) == 0) begin
                w0 = w[0];
                w[0] = sub_tab[w[1]] ^ rc;
                w[1] = sub_tab[w[2]];
                w[2] = sub_tab[w[3]];
                w[3] = sub_tab[w0];
                rc = gmul2(rc);
            end
            for (int c = 0; c < 4; c++) rk[i+c] = rk[i-16+c] ^ w[c];
        end
        for (int i = 0; i < 16; i++) st[i] = blk[i] ^ rk[i];
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++) tt[c*4+i] = sub_tab[st[((c+i)%4)*4+i]];
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = tt[c*4]; a1 = tt[c*4+1]; a2 = tt[c*4+2]; a3 = tt[c*4+3];
                    al = a0 ^ a1 ^ a2 ^ a3;
                    tt[c*4]   = a0 ^ al ^ gmul2(a0 ^ a1);
                    tt[c*4+1] = a1 ^ al ^ gmul2(a1 ^ a2);
                    tt[c*4+2] = a2 ^ al ^ gmul2(a2 ^ a3);
                    tt[c*4+3] = a3 ^ al ^ gmul2(a3 ^ a0);
                end
            end
            for (int i = 0; i < 16; i++) st[i] = tt[i] ^ rk[r*16+i];
        end
        return {st[3], st[2], st[1], st[0]};
    endfunction

    task automatic predict_digest(input t_in_item it);
        logic [7:0] blk [16];
        int f;
        t_out_item res;
        if (it.start_message) begin
            model_len = '0;
            model_fill = '0;
            if (it.restart_from_iv) model_chain = model_iv;
        end
        if (it.byte_present) begin
            model_buf[model_fill[3:0]] = it.data_byte;
            model_fill = model_fill + 5'd1;
            model_len = model_len + 64'd1;
            if (model_fill >= 5'd16) begin
                model_chain = compress(model_chain, model_buf);
                model_fill = '0;
            end
        end
        if (it.end_message) begin
            f = model_fill[3:0];
            res.partial_dropped = 1'b0;
            if (model_pad) begin
                for (int i = 0; i < 16; i++) blk[i] = (i < f) ? model_buf[i] : 8'h00;
                blk[f] = PAD_BYTE;
                if (f >= 8) begin
                    model_chain = compress(model_chain, blk);
                    for (int i = 0; i < 16; i++) blk[i] = 8'h00;
                end
                for (int i = 0; i < 8; i++) blk[8+i] = model_len[8*i +: 8];
                model_chain = compress(model_chain, blk);
            end else begin
                res.partial_dropped = (f != 0);
            end
            res.digest = model_chain;
            expected_digests.push_back(res);
            model_fill = '0;
            model_len = '0;
        end
    endtask

    function automatic t_in_item mk(input logic [7:0] d, input logic p, input logic s,
                                    input logic r, input logic e);
        t_in_item it;
        it.data_byte = d; it.byte_present = p; it.start_message = s;
        it.restart_from_iv = r; it.end_message = e;
        return it;
    endfunction

    task automatic queue_message(input int n, input logic from_iv);
        for (int i = 0; i < n; i++)
            pending_items.push_back(mk(8'($urandom_range(0, 255)), 1'b1, i == 0, from_iv,
                                        i == n - 1));
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || i_valid || expected_digests.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_IV) model_iv = val;
        else model_pad = val[0];
    endtask

    task automatic random_phase(input int n_items);
        int sent;
        int len;
        int kind;
        t_in_item it;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 9);
            if (kind < 7) begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 17);
                queue_message(len, 1'($urandom_range(0, 1)));
                sent += len;
            end else begin
                it = mk(8'($urandom()), 1'($urandom()), 1'($urandom()), 1'($urandom()),
                        1'($urandom()));
                pending_items.push_back(it);
                sent++;
            end
        end
    endtask

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) predict_digest(i_item);
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
                i_item <= pending_items.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_digests.size() == 0) begin
                $display("%0t unexpected result expected none actual %h", $time, o_item);
                errors++;
            end else begin
                want = expected_digests.pop_front();
                if (o_item.digest !== want.digest) begin
                    $display("%0t digest expected %h actual %h", $time, want.digest,
                             o_item.digest);
                    errors++;
                end
                if (o_item.partial_dropped !== want.partial_dropped) begin
                    $display("%0t partial_dropped expected %b actual %b", $time,
                             want.partial_dropped, o_item.partial_dropped);
                    errors++;
                end
            end
        end
        if (!i_rst_n) i_stall <= 1'b0;
        else if (hold_cycles > 0) begin
            i_stall <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else i_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_clk = 1'b0;
        errors = 0;
        cycle_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_IV;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_item = '0;
        model_iv = IV_RESET;
        model_pad = 1'b1;
        model_chain = IV_RESET;
        model_fill = '0;
        model_len = '0;
        for (int i = 0; i < 16; i++) model_buf[i] = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty message, pad boundaries, restart without start, chaining
        pending_items.push_back(mk(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        queue_message(7, 1'b1);
        queue_message(8, 1'b0);
        queue_message(16, 1'b1);
        pending_items.push_back(mk(8'hff, 1'b1, 1'b1, 1'b0, 1'b0));
        pending_items.push_back(mk(8'h00, 1'b1, 1'b0, 1'b1, 1'b0));
        pending_items.push_back(mk(8'h80, 1'b0, 1'b0, 1'b0, 1'b1));
        wait_idle();
        write_reg(CFG_PAD, 32'h0);
        write_reg(CFG_IV, 32'hffffffff);
        queue_message(5, 1'b1);
        queue_message(16, 1'b0);
        pending_items.push_back(mk(8'h00, 1'b0, 1'b1, 1'b1, 1'b1));
        wait_idle();
        write_reg(CFG_PAD, 32'h1);
        write_reg(CFG_IV, 32'h0);

        random_phase(400);
        wait_idle();
        sender_idle_pct = 73;
        write_reg(CFG_IV, $urandom());
        random_phase(400);
        wait_idle();
        sender_idle_pct = 0;
        receiver_stall_pct = 73;
        write_reg(CFG_PAD, 32'h0);
        random_phase(400);
        wait_idle();
        sender_idle_pct = 22;
        receiver_stall_pct = 22;
        write_reg(CFG_PAD, 32'h1);
        write_reg(CFG_IV, $urandom());
        random_phase(350);
        wait_idle();
        // long receiver hold-off while the sender keeps going
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_cycles = 600;
        for (int i = 0; i < 20; i++) queue_message($urandom_range(1, 9), 1'b0);
        random_phase(150);
        wait_idle();

        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire
